/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pso_pkg.sv */
// ----------------------------------------------------------------------------
// PSO update package
// Widths, reset values, register indexes and pipeline sideband types.
// ----------------------------------------------------------------------------
package pso_pkg;

    localparam int COORD_W    = 32;
    localparam int STEP_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Gains are Q2.14, so a gain times a Q0.16 fraction drops 14 bits.
    localparam int GAIN_FRAC  = 14;
    localparam int RHO_PROD_W = GAIN_W + FRAC_W;
    localparam int RHO_W      = RHO_PROD_W - GAIN_FRAC;

    localparam int DIFF_W     = COORD_W + 1;
    localparam int PW_W       = GAIN_W + 1 + COORD_W;
    localparam int PB_W       = RHO_W + 1 + DIFF_W;
    localparam int ACC_W      = PB_W + 2;
    localparam int VEL_SHIFT  = 16;
    localparam int SH_W       = ACC_W - VEL_SHIFT;

    // Inertia quotient unit.
    localparam int NUM_W      = 32;
    localparam int QUOT_W     = 16;
    localparam int DIV_PER    = 4;
    localparam int DIV_STAGES = QUOT_W / DIV_PER;

    // Wrap remainder unit.
    localparam int MOD_D_W    = DIFF_W;
    localparam int MOD_PER    = 4;
    localparam int MOD_STAGES = (MOD_D_W + MOD_PER - 1) / MOD_PER;
    localparam int MOD_N_W    = MOD_STAGES * MOD_PER;

    localparam int TOTAL_STEPS_RST = 500;
    localparam logic [GAIN_W-1:0] WEIGHT_MIN_RST = 16'd19661;
    localparam logic [GAIN_W-1:0] WEIGHT_MAX_RST = 16'd47828;
    localparam logic [GAIN_W-1:0] COG_GAIN_RST   = 16'd24510;
    localparam logic [GAIN_W-1:0] SOC_GAIN_RST   = 16'd24510;
    localparam logic [STEP_W-1:0] STAGE_RST      = STEP_W'(3 * TOTAL_STEPS_RST / 4);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_MIN     = 3'd0,
        REG_WEIGHT_MAX     = 3'd1,
        REG_COGNITIVE_GAIN = 3'd2,
        REG_SOCIAL_GAIN    = 3'd3,
        REG_TOTAL_STEPS    = 3'd4,
        REG_CLAMP_MODE     = 3'd5
    } cfg_reg_t;

    // Fields that ride alongside the inertia quotient and the products.
    typedef struct packed {
        logic                      sel_min;
        logic                      neg;
        logic signed [COORD_W-1:0] position;
        logic signed [COORD_W-1:0] velocity;
        logic signed [COORD_W-1:0] lower_bound;
        logic signed [COORD_W-1:0] upper_bound;
        logic signed [DIFF_W-1:0]  pb_diff;
        logic signed [DIFF_W-1:0]  nb_diff;
        logic [RHO_W-1:0]          rho1;
        logic [RHO_W-1:0]          rho2;
    } upd_side_t;

    // Fields that ride alongside the wrap remainder.
    typedef struct packed {
        logic                      below;
        logic                      above;
        logic                      range_pos;
        logic [COORD_W-1:0]        moved;
        logic [COORD_W-1:0]        vel;
        logic [COORD_W-1:0]        lower_bound;
        logic [COORD_W-1:0]        upper_bound;
    } wrap_side_t;

endpackage

/* src/pso_if.sv */
// ----------------------------------------------------------------------------
// PSO update channels
// Valid/ready channels for configuration, input words and result words.
// ----------------------------------------------------------------------------
interface pso_cfg_if import pso_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface pso_item_if import pso_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STEP_W-1:0]         step_index;
    logic signed [COORD_W-1:0] position;
    logic signed [COORD_W-1:0] velocity;
    logic signed [COORD_W-1:0] personal_best;
    logic signed [COORD_W-1:0] neighbour_best;
    logic signed [COORD_W-1:0] lower_bound;
    logic signed [COORD_W-1:0] upper_bound;
    logic [FRAC_W-1:0]         random_one;
    logic [FRAC_W-1:0]         random_two;

    modport source (output valid, step_index, position, velocity, personal_best,
                    neighbour_best, lower_bound, upper_bound, random_one, random_two,
                    input ready);
    modport sink (input valid, step_index, position, velocity, personal_best,
                  neighbour_best, lower_bound, upper_bound, random_one, random_two,
                  output ready);
endinterface

interface pso_result_if import pso_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] new_position;
    logic signed [COORD_W-1:0] new_velocity;
    logic                      bound_hit;

    modport source (output valid, new_position, new_velocity, bound_hit, input ready);
    modport sink (input valid, new_position, new_velocity, bound_hit, output ready);
endinterface

/* src/pso_weight_div.sv */
// ----------------------------------------------------------------------------
// PSO inertia quotient unit
// Pipelined restoring divider for the inertia schedule quotient.
// ----------------------------------------------------------------------------
module pso_weight_div import pso_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  num,
    input  logic [QUOT_W-1:0] divisor,
    input  upd_side_t         in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [QUOT_W-1:0] quot,
    output upd_side_t         out_side
);

    localparam int REM_W = NUM_W - QUOT_W;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [REM_W-1:0]      rem_reg  [DIV_STAGES];
    logic [QUOT_W-1:0]     bits_reg [DIV_STAGES];
    upd_side_t             side_reg [DIV_STAGES];

    logic [DIV_STAGES-1:0] valid_src;
    logic [REM_W-1:0]      rem_src   [DIV_STAGES];
    logic [QUOT_W-1:0]     bits_src  [DIV_STAGES];
    upd_side_t             side_src  [DIV_STAGES];
    logic [REM_W-1:0]      rem_next  [DIV_STAGES];
    logic [QUOT_W-1:0]     bits_next [DIV_STAGES];
    logic [DIV_STAGES:0]   rdy;

    // The quotient is known to fit QUOT_W bits, so the upper half of the
    // numerator is already below the divisor and seeds the remainder.
    always_comb
    begin
        valid_src[0] = in_valid;
        rem_src[0]   = num[NUM_W-1:QUOT_W];
        bits_src[0]  = num[QUOT_W-1:0];
        side_src[0]  = in_side;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            valid_src[s] = valid_reg[s-1];
            rem_src[s]   = rem_reg[s-1];
            bits_src[s]  = bits_reg[s-1];
            side_src[s]  = side_reg[s-1];
        end
    end

    always_comb
    begin
        logic [REM_W:0]    trial;
        logic [REM_W-1:0]  rem_v;
        logic [QUOT_W-1:0] bits_v;
        trial = '0;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_v  = rem_src[s];
            bits_v = bits_src[s];
            for (int i = 0; i < DIV_PER; i++)
            begin
                trial  = {rem_v, bits_v[QUOT_W-1]};
                bits_v = {bits_v[QUOT_W-2:0], 1'b0};
                if (trial >= {1'b0, divisor})
                begin
                    trial     = trial - {1'b0, divisor};
                    bits_v[0] = 1'b1;
                end
                rem_v = trial[REM_W-1:0];
            end
            rem_next[s]  = rem_v;
            bits_next[s] = bits_v;
        end
    end

    always_comb
    begin
        rdy[DIV_STAGES] = out_ready;
        for (int s = DIV_STAGES - 1; s >= 0; s--)
        begin
            rdy[s] = !valid_reg[s] || rdy[s+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                if (rdy[s])
                begin
                    valid_reg[s] <= valid_src[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (rdy[s])
            begin
                rem_reg[s]  <= rem_next[s];
                bits_reg[s] <= bits_next[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quot      = bits_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

/* src/pso_wrap_mod.sv */
// ----------------------------------------------------------------------------
// PSO wrap remainder unit
// Pipelined restoring remainder of the overshoot modulo the search range.
// ----------------------------------------------------------------------------
module pso_wrap_mod import pso_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [MOD_D_W-1:0] dividend,
    input  logic [MOD_D_W-1:0] divisor,
    input  wrap_side_t         in_side,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MOD_D_W-1:0] rem,
    output wrap_side_t         out_side
);

    logic [MOD_STAGES-1:0] valid_reg;
    logic [MOD_D_W-1:0]    rem_reg  [MOD_STAGES];
    logic [MOD_N_W-1:0]    bits_reg [MOD_STAGES];
    logic [MOD_D_W-1:0]    div_reg  [MOD_STAGES];
    wrap_side_t            side_reg [MOD_STAGES];

    logic [MOD_STAGES-1:0] valid_src;
    logic [MOD_D_W-1:0]    rem_src   [MOD_STAGES];
    logic [MOD_N_W-1:0]    bits_src  [MOD_STAGES];
    logic [MOD_D_W-1:0]    div_src   [MOD_STAGES];
    wrap_side_t            side_src  [MOD_STAGES];
    logic [MOD_D_W-1:0]    rem_next  [MOD_STAGES];
    logic [MOD_N_W-1:0]    bits_next [MOD_STAGES];
    logic [MOD_STAGES:0]   rdy;

    always_comb
    begin
        valid_src[0] = in_valid;
        rem_src[0]   = '0;
        bits_src[0]  = {{(MOD_N_W-MOD_D_W){1'b0}}, dividend};
        div_src[0]   = divisor;
        side_src[0]  = in_side;
        for (int s = 1; s < MOD_STAGES; s++)
        begin
            valid_src[s] = valid_reg[s-1];
            rem_src[s]   = rem_reg[s-1];
            bits_src[s]  = bits_reg[s-1];
            div_src[s]   = div_reg[s-1];
            side_src[s]  = side_reg[s-1];
        end
    end

    // Only the remainder is kept; the dividend bits simply shift out.
    always_comb
    begin
        logic [MOD_D_W:0]   trial;
        logic [MOD_D_W-1:0] rem_v;
        logic [MOD_N_W-1:0] bits_v;
        trial = '0;
        for (int s = 0; s < MOD_STAGES; s++)
        begin
            rem_v  = rem_src[s];
            bits_v = bits_src[s];
            for (int i = 0; i < MOD_PER; i++)
            begin
                trial  = {rem_v, bits_v[MOD_N_W-1]};
                bits_v = {bits_v[MOD_N_W-2:0], 1'b0};
                if (trial >= {1'b0, div_src[s]})
                begin
                    trial = trial - {1'b0, div_src[s]};
                end
                rem_v = trial[MOD_D_W-1:0];
            end
            rem_next[s]  = rem_v;
            bits_next[s] = bits_v;
        end
    end

    always_comb
    begin
        rdy[MOD_STAGES] = out_ready;
        for (int s = MOD_STAGES - 1; s >= 0; s--)
        begin
            rdy[s] = !valid_reg[s] || rdy[s+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < MOD_STAGES; s++)
            begin
                if (rdy[s])
                begin
                    valid_reg[s] <= valid_src[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < MOD_STAGES; s++)
        begin
            if (rdy[s])
            begin
                rem_reg[s]  <= rem_next[s];
                bits_reg[s] <= bits_next[s];
                div_reg[s]  <= div_src[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[MOD_STAGES-1];
    assign rem       = rem_reg[MOD_STAGES-1];
    assign out_side  = side_reg[MOD_STAGES-1];

endmodule

/* src/pso_particle_update.sv */
// ----------------------------------------------------------------------------
// PSO particle coordinate update
// One coordinate of one particle per word: inertia schedule, velocity update,
// and clamping or periodic wrapping of the new position into its bounds.
// ----------------------------------------------------------------------------
// The block takes one input word per clock unless a full pipeline is held
// by a stalled output, and returns one result word per input word, in
// order. The path runs through one input stage, four stages of the inertia
// quotient divider (four quotient bits per stage), six arithmetic stages,
// nine stages of the wrap remainder unit (four remainder bits per stage)
// and the output register. Every stage holds its own valid bit and moves up
// whenever the stage after it is empty or moving, so bubbles close up and
// input keeps flowing while a finished result waits at the output.
// Configuration writes are always taken and must only be issued while no
// word is in flight; the total_steps register is kept internally as its
// schedule stage of three quarters of the run.

module pso_particle_update import pso_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    pso_cfg_if.sink       cfg,
    pso_item_if.sink      item,
    pso_result_if.source  result
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] weight_min_reg;
    logic [GAIN_W-1:0] weight_max_reg;
    logic [GAIN_W-1:0] cog_gain_reg;
    logic [GAIN_W-1:0] soc_gain_reg;
    logic [STEP_W-1:0] stage_reg;
    logic              clamp_mode_reg;

    // Three quarters of the run, rounded down.
    function automatic logic [STEP_W-1:0] run_stage(input logic [STEP_W-1:0] steps);
        logic [STEP_W+1:0] triple;
        triple = {2'b00, steps} + {1'b0, steps, 1'b0};
        return triple[STEP_W+1:2];
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_min_reg <= WEIGHT_MIN_RST;
            weight_max_reg <= WEIGHT_MAX_RST;
            cog_gain_reg   <= COG_GAIN_RST;
            soc_gain_reg   <= SOC_GAIN_RST;
            stage_reg      <= STAGE_RST;
            clamp_mode_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_WEIGHT_MIN:     weight_min_reg <= cfg.data;
                REG_WEIGHT_MAX:     weight_max_reg <= cfg.data;
                REG_COGNITIVE_GAIN: cog_gain_reg   <= cfg.data;
                REG_SOCIAL_GAIN:    soc_gain_reg   <= cfg.data;
                REG_TOTAL_STEPS:    stage_reg      <= run_stage(cfg.data);
                REG_CLAMP_MODE:     clamp_mode_reg <= cfg.data[0];
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input stage: schedule numerator, random coefficients, best offsets.
    // The weight offset is |w_max - w_min| * (stage - step), later divided
    // by the stage; its sign is applied after the divider. Steps past the
    // schedule, or an empty schedule, use w_min directly.
    // ------------------------------------------------------------------
    logic                    sel_min;
    logic [STEP_W-1:0]       steps_left;
    logic signed [GAIN_W:0]  w_diff;
    logic [GAIN_W:0]         w_abs;
    logic [RHO_PROD_W-1:0]   rho1_prod;
    logic [RHO_PROD_W-1:0]   rho2_prod;
    upd_side_t               in_side;
    logic [NUM_W-1:0]        num_next;

    logic                    s0_valid_reg;
    logic [NUM_W-1:0]        s0_num_reg;
    upd_side_t               s0_side_reg;
    logic                    s0_rdy;
    logic                    div_in_ready;

    assign sel_min    = (stage_reg == '0) || (item.step_index > stage_reg);
    assign steps_left = stage_reg - item.step_index;
    assign w_diff     = $signed({1'b0, weight_max_reg}) - $signed({1'b0, weight_min_reg});
    assign w_abs      = w_diff[GAIN_W] ? 17'(-w_diff) : 17'(w_diff);
    assign num_next   = sel_min ? '0 : NUM_W'(w_abs[GAIN_W-1:0]) * NUM_W'(steps_left);
    assign rho1_prod  = RHO_PROD_W'(cog_gain_reg) * RHO_PROD_W'(item.random_one);
    assign rho2_prod  = RHO_PROD_W'(soc_gain_reg) * RHO_PROD_W'(item.random_two);

    always_comb
    begin
        in_side.sel_min     = sel_min;
        in_side.neg         = w_diff[GAIN_W];
        in_side.position    = item.position;
        in_side.velocity    = item.velocity;
        in_side.lower_bound = item.lower_bound;
        in_side.upper_bound = item.upper_bound;
        in_side.pb_diff     = DIFF_W'(item.personal_best) - DIFF_W'(item.position);
        in_side.nb_diff     = DIFF_W'(item.neighbour_best) - DIFF_W'(item.position);
        in_side.rho1        = rho1_prod[RHO_PROD_W-1:GAIN_FRAC];
        in_side.rho2        = rho2_prod[RHO_PROD_W-1:GAIN_FRAC];
    end

    assign s0_rdy     = !s0_valid_reg || div_in_ready;
    assign item.ready = s0_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_rdy)
        begin
            s0_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_rdy)
        begin
            s0_num_reg  <= num_next;
            s0_side_reg <= in_side;
        end
    end

    // ------------------------------------------------------------------
    // Inertia quotient, pipelined over four stages.
    // ------------------------------------------------------------------
    logic              div_valid;
    logic [QUOT_W-1:0] div_quot;
    upd_side_t         div_side;
    logic              sw_rdy;

    pso_weight_div u_weight_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_ready  (div_in_ready),
        .num       (s0_num_reg),
        .divisor   (stage_reg),
        .in_side   (s0_side_reg),
        .out_valid (div_valid),
        .out_ready (sw_rdy),
        .quot      (div_quot),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Weight stage: apply the sign of the schedule slope.
    // ------------------------------------------------------------------
    logic              sw_valid_reg;
    logic [GAIN_W-1:0] sw_w_reg;
    upd_side_t         sw_side_reg;
    logic [GAIN_W-1:0] w_next;
    logic              sm_rdy;

    always_comb
    begin
        if (div_side.sel_min)
        begin
            w_next = weight_min_reg;
        end
        else if (div_side.neg)
        begin
            w_next = weight_min_reg - div_quot;
        end
        else
        begin
            w_next = weight_min_reg + div_quot;
        end
    end

    assign sw_rdy = !sw_valid_reg || sm_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_valid_reg <= 1'b0;
        end
        else if (sw_rdy)
        begin
            sw_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sw_rdy)
        begin
            sw_w_reg    <= w_next;
            sw_side_reg <= div_side;
        end
    end

    // ------------------------------------------------------------------
    // Product stage: the three velocity terms, exact in units of 2^-32.
    // ------------------------------------------------------------------
    logic                    sm_valid_reg;
    logic signed [PW_W-1:0]  sm_pw_reg;
    logic signed [PB_W-1:0]  sm_p1_reg;
    logic signed [PB_W-1:0]  sm_p2_reg;
    upd_side_t               sm_side_reg;
    logic signed [PW_W-1:0]  pw_next;
    logic signed [PB_W-1:0]  p1_next;
    logic signed [PB_W-1:0]  p2_next;
    logic                    ss_rdy;

    assign pw_next = PW_W'($signed({1'b0, sw_w_reg})) * PW_W'(sw_side_reg.velocity);
    assign p1_next = PB_W'($signed({1'b0, sw_side_reg.rho1})) * PB_W'(sw_side_reg.pb_diff);
    assign p2_next = PB_W'($signed({1'b0, sw_side_reg.rho2})) * PB_W'(sw_side_reg.nb_diff);
    assign sm_rdy  = !sm_valid_reg || ss_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_valid_reg <= 1'b0;
        end
        else if (sm_rdy)
        begin
            sm_valid_reg <= sw_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sm_rdy)
        begin
            sm_pw_reg   <= pw_next;
            sm_p1_reg   <= p1_next;
            sm_p2_reg   <= p2_next;
            sm_side_reg <= sw_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sum stage.
    // ------------------------------------------------------------------
    logic                    ss_valid_reg;
    logic signed [ACC_W-1:0] ss_acc_reg;
    upd_side_t               ss_side_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic                    sv_rdy;

    assign acc_next = ACC_W'(sm_pw_reg) + ACC_W'(sm_p1_reg) + ACC_W'(sm_p2_reg);
    assign ss_rdy   = !ss_valid_reg || sv_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_valid_reg <= 1'b0;
        end
        else if (ss_rdy)
        begin
            ss_valid_reg <= sm_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ss_rdy)
        begin
            ss_acc_reg  <= acc_next;
            ss_side_reg <= sm_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Velocity stage: floor to Q16.16 by dropping the low bits, then
    // saturate to the signed 32-bit range.
    // ------------------------------------------------------------------
    logic                      sv_valid_reg;
    logic signed [COORD_W-1:0] sv_vel_reg;
    upd_side_t                 sv_side_reg;
    logic [SH_W-1:0]           vel_wide;
    logic [SH_W-COORD_W:0]     vel_top;
    logic signed [COORD_W-1:0] vel_next;
    logic                      sp_rdy;

    assign vel_wide = ss_acc_reg[ACC_W-1:VEL_SHIFT];
    assign vel_top  = vel_wide[SH_W-1:COORD_W-1];

    always_comb
    begin
        if (vel_top == '0 || vel_top == '1)
        begin
            vel_next = vel_wide[COORD_W-1:0];
        end
        else if (vel_wide[SH_W-1])
        begin
            vel_next = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            vel_next = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    assign sv_rdy = !sv_valid_reg || sp_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_valid_reg <= 1'b0;
        end
        else if (sv_rdy)
        begin
            sv_valid_reg <= ss_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sv_rdy)
        begin
            sv_vel_reg  <= vel_next;
            sv_side_reg <= ss_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Move stage: new position, exact in 33 bits, and the bound tests.
    // ------------------------------------------------------------------
    logic                     sp_valid_reg;
    logic signed [DIFF_W-1:0] sp_moved_reg;
    logic                     sp_below_reg;
    logic                     sp_above_reg;
    logic [COORD_W-1:0]       sp_vel_reg;
    logic signed [COORD_W-1:0] sp_lo_reg;
    logic signed [COORD_W-1:0] sp_hi_reg;
    logic signed [DIFF_W-1:0] moved_next;
    logic                     sd_rdy;

    assign moved_next = DIFF_W'(sv_side_reg.position) + DIFF_W'(sv_vel_reg);
    assign sp_rdy     = !sp_valid_reg || sd_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_valid_reg <= 1'b0;
        end
        else if (sp_rdy)
        begin
            sp_valid_reg <= sv_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sp_rdy)
        begin
            sp_moved_reg <= moved_next;
            sp_below_reg <= moved_next < DIFF_W'(sv_side_reg.lower_bound);
            sp_above_reg <= moved_next > DIFF_W'(sv_side_reg.upper_bound);
            sp_vel_reg   <= sv_vel_reg;
            sp_lo_reg    <= sv_side_reg.lower_bound;
            sp_hi_reg    <= sv_side_reg.upper_bound;
        end
    end

    // ------------------------------------------------------------------
    // Wrap setup stage: overshoot beyond the violated bound and the range.
    // Both are formed for every word; the remainder is used only on a wrap.
    // ------------------------------------------------------------------
    logic                     sd_valid_reg;
    logic [MOD_D_W-1:0]       sd_dividend_reg;
    logic [MOD_D_W-1:0]       sd_range_reg;
    wrap_side_t               sd_side_reg;
    logic signed [DIFF_W:0]   over_next;
    logic signed [DIFF_W-1:0] range_next;
    wrap_side_t               wrap_next;
    logic                     mod_in_ready;

    assign over_next  = sp_below_reg ? ((DIFF_W+1)'(sp_lo_reg) - (DIFF_W+1)'(sp_moved_reg))
                                     : ((DIFF_W+1)'(sp_moved_reg) - (DIFF_W+1)'(sp_hi_reg));
    assign range_next = DIFF_W'(sp_hi_reg) - DIFF_W'(sp_lo_reg);

    always_comb
    begin
        wrap_next.below       = sp_below_reg;
        wrap_next.above       = sp_above_reg;
        wrap_next.range_pos   = !range_next[DIFF_W-1] && (range_next != '0);
        wrap_next.moved       = sp_moved_reg[COORD_W-1:0];
        wrap_next.vel         = sp_vel_reg;
        wrap_next.lower_bound = sp_lo_reg;
        wrap_next.upper_bound = sp_hi_reg;
    end

    assign sd_rdy = !sd_valid_reg || mod_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_valid_reg <= 1'b0;
        end
        else if (sd_rdy)
        begin
            sd_valid_reg <= sp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sd_rdy)
        begin
            sd_dividend_reg <= over_next[MOD_D_W-1:0];
            sd_range_reg    <= range_next;
            sd_side_reg     <= wrap_next;
        end
    end

    // ------------------------------------------------------------------
    // Wrap remainder, pipelined over nine stages.
    // ------------------------------------------------------------------
    logic               mod_valid;
    logic [MOD_D_W-1:0] mod_rem;
    wrap_side_t         mod_side;
    logic               out_rdy;

    pso_wrap_mod u_wrap_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sd_valid_reg),
        .in_ready  (mod_in_ready),
        .dividend  (sd_dividend_reg),
        .divisor   (sd_range_reg),
        .in_side   (sd_side_reg),
        .out_valid (mod_valid),
        .out_ready (out_rdy),
        .rem       (mod_rem),
        .out_side  (mod_side)
    );

    // ------------------------------------------------------------------
    // Output register. A wrapped result lies inside the bounds, so plain
    // 32-bit arithmetic is exact here. An empty or inverted range falls
    // back to clamping even in wrap mode.
    // ------------------------------------------------------------------
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_pos_reg;
    logic [COORD_W-1:0] out_vel_reg;
    logic               out_hit_reg;
    logic               hit;
    logic               wrap;
    logic [COORD_W-1:0] pos_next;

    assign hit  = mod_side.below || mod_side.above;
    assign wrap = !clamp_mode_reg && mod_side.range_pos;

    always_comb
    begin
        if (!hit)
        begin
            pos_next = mod_side.moved;
        end
        else if (!wrap)
        begin
            pos_next = mod_side.below ? mod_side.lower_bound : mod_side.upper_bound;
        end
        else if (mod_side.below)
        begin
            pos_next = mod_side.upper_bound - mod_rem[COORD_W-1:0];
        end
        else
        begin
            pos_next = mod_side.lower_bound + mod_rem[COORD_W-1:0];
        end
    end

    assign out_rdy = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            out_valid_reg <= mod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
        begin
            out_pos_reg <= pos_next;
            out_vel_reg <= hit ? '0 : mod_side.vel;
            out_hit_reg <= hit;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.new_position = out_pos_reg;
    assign result.new_velocity = out_vel_reg;
    assign result.bound_hit    = out_hit_reg;

endmodule

/* src/pso_checker.sv */
// ----------------------------------------------------------------------------
// PSO update port checker
// Watches the ports of the update block and flags protocol and result slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pso_checker import pso_pkg::*; (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      item_valid,
    input logic                      item_ready,
    input logic                      result_valid,
    input logic                      result_ready,
    input logic signed [COORD_W-1:0] new_position,
    input logic signed [COORD_W-1:0] new_velocity,
    input logic                      bound_hit
);

    localparam int PEND_W = 6;

    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic              in_acc;
    logic              out_acc;

    assign in_acc       = item_valid && item_ready;
    assign out_acc      = result_valid && result_ready;
    assign pending_next = pending_reg + PEND_W'(in_acc) - PEND_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A waiting result word holds until it is taken.
    `ASSERT_CLK(a_result_hold, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(new_position) && $stable(new_velocity) && $stable(bound_hit), "result word changed while stalled")

    // A bound hit always comes with a zero velocity.
    `ASSERT_CLK(a_hit_zero_vel, clk, rst_n, result_valid && bound_hit |-> new_velocity == '0, "bound hit with nonzero velocity")

    // Every result word belongs to an accepted input word.
    `ASSERT_CLK(a_no_spurious, clk, rst_n, result_valid |-> pending_reg != '0, "result word without a pending input word")

    // Reset empties the pipeline by the next edge.
    `ASSERT_CLK_ALWAYS(a_reset_idle, clk, !rst_n |=> !result_valid, "result valid during reset")

endmodule

bind pso_particle_update pso_checker u_pso_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .new_position (result.new_position),
    .new_velocity (result.new_velocity),
    .bound_hit    (result.bound_hit)
);
